[rtl/nnsb_pkg.sv]
// shared constants, codes and types for the nearest-neighbor stretch blit
// no dependencies
package nnsb_pkg;

    localparam int COORD_W           = 12;
    localparam int PIXEL_W           = 16;
    localparam int CFG_DATA_W        = 13;
    localparam int CFG_IDX_W         = 3;
    localparam int MAX_DIMENSION_DEF = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_DEST_WIDTH    = 3'd2,
        CFG_DEST_HEIGHT   = 3'd3,
        CFG_KEY_ENABLE    = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LAUNCH,
        SEQ_WAIT
    } t_seq_state;

    typedef enum logic [1:0] {
        JOB_HSTEP,
        JOB_VSTEP,
        JOB_HNORM,
        JOB_VNORM
    } t_div_job;

    typedef struct packed {
        logic h_load;
        logic v_load;
    } t_norm_ctl;

endpackage

[rtl/nnsb_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on nnsb_pkg
module nnsb_div
    import nnsb_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [$clog2(MAX_DIMENSION+1)-1:0]    i_numer,
    input  logic [$clog2(MAX_DIMENSION+1)-1:0]    i_denom,
    output logic [$clog2(MAX_DIMENSION+1)-1:0]    o_quo,
    output logic [$clog2(MAX_DIMENSION+1)-1:0]    o_rem,
    output logic                                  o_done
);

    localparam int ESZ_W = $clog2(MAX_DIMENSION + 1);
    localparam int CW    = $clog2(ESZ_W + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [ESZ_W-1:0] r_rem;
    logic [ESZ_W-1:0] r_quo;
    logic [ESZ_W:0]   t_shift;
    logic             t_ge;
    logic [ESZ_W-1:0] n_rem;
    logic [ESZ_W-1:0] n_quo;

    always_comb begin
        t_shift = {r_rem, r_quo[ESZ_W-1]};
        t_ge    = t_shift >= {1'b0, i_denom};
        n_rem   = t_ge ? ESZ_W'(t_shift - {1'b0, i_denom}) : t_shift[ESZ_W-1:0];
        n_quo   = {r_quo[ESZ_W-2:0], t_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(ESZ_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_numer;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

[rtl/nnsb_cfg.sv]
// configuration registers and step sequencer; derives whole and fractional
// steps and renormalizes the error accumulators after every write
// depends on nnsb_pkg and nnsb_div
module nnsb_cfg
    import nnsb_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                 i_cfg_data,
    input  logic [$clog2(MAX_DIMENSION)-1:0]      i_herr,
    input  logic [$clog2(MAX_DIMENSION)-1:0]      i_verr,
    output logic                                  o_busy,
    output logic [$clog2(MAX_DIMENSION+1)-1:0]    o_dw,
    output logic [$clog2(MAX_DIMENSION+1)-1:0]    o_dh,
    output logic [COORD_W-1:0]                    o_h_whole,
    output logic [COORD_W-1:0]                    o_v_whole,
    output logic [$clog2(MAX_DIMENSION)-1:0]      o_h_frac,
    output logic [$clog2(MAX_DIMENSION)-1:0]      o_v_frac,
    output logic                                  o_key_enable,
    output t_norm_ctl                             o_norm,
    output logic [COORD_W-1:0]                    o_norm_quo,
    output logic [$clog2(MAX_DIMENSION)-1:0]      o_norm_rem
);

    localparam int ESZ_W = $clog2(MAX_DIMENSION + 1);
    localparam int CNT_W = $clog2(MAX_DIMENSION);

    function automatic logic [ESZ_W-1:0] f_eff(input logic [CFG_DATA_W-1:0] v);
        logic [ESZ_W-1:0] res;
        if (v == '0) begin
            res = ESZ_W'(1);
        end else if (32'(v) > MAX_DIMENSION) begin
            res = ESZ_W'(MAX_DIMENSION);
        end else begin
            res = ESZ_W'(v);
        end
        return res;
    endfunction

    logic [CFG_DATA_W-1:0] r_src_w;
    logic [CFG_DATA_W-1:0] r_src_h;
    logic [CFG_DATA_W-1:0] r_dst_w;
    logic [CFG_DATA_W-1:0] r_dst_h;
    logic                  r_key;
    logic [COORD_W-1:0]    r_h_whole;
    logic [COORD_W-1:0]    r_v_whole;
    logic [CNT_W-1:0]      r_h_frac;
    logic [CNT_W-1:0]      r_v_frac;
    t_seq_state            r_state;
    t_seq_state            n_state;
    t_div_job              r_job;
    t_div_job              n_job;

    logic             cfg_wr;
    logic             div_start;
    logic             div_done;
    logic [ESZ_W-1:0] div_numer;
    logic [ESZ_W-1:0] div_denom;
    logic [ESZ_W-1:0] div_quo;
    logic [ESZ_W-1:0] div_rem;
    logic [ESZ_W-1:0] eff_sw;
    logic [ESZ_W-1:0] eff_sh;
    logic [ESZ_W-1:0] eff_dw;
    logic [ESZ_W-1:0] eff_dh;
    logic             job_end;

    assign eff_sw = f_eff(r_src_w);
    assign eff_sh = f_eff(r_src_h);
    assign eff_dw = f_eff(r_dst_w);
    assign eff_dh = f_eff(r_dst_h);

    assign o_cfg_ready = (r_state == SEQ_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign job_end     = (r_state == SEQ_WAIT) && div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_job   <= JOB_HSTEP;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        div_start = 1'b0;
        o_norm    = '0;
        case (r_job)
            JOB_HSTEP: begin
                div_numer = eff_sw;
                div_denom = eff_dw;
            end
            JOB_VSTEP: begin
                div_numer = eff_sh;
                div_denom = eff_dh;
            end
            JOB_HNORM: begin
                div_numer = ESZ_W'(i_herr);
                div_denom = eff_dw;
            end
            default: begin
                div_numer = ESZ_W'(i_verr);
                div_denom = eff_dh;
            end
        endcase
        case (r_state)
            SEQ_IDLE: begin
                if (cfg_wr) begin
                    n_state = SEQ_LAUNCH;
                    n_job   = JOB_HSTEP;
                end
            end
            SEQ_LAUNCH: begin
                div_start = 1'b1;
                n_state   = SEQ_WAIT;
            end
            SEQ_WAIT: begin
                if (div_done) begin
                    o_norm.h_load = (r_job == JOB_HNORM);
                    o_norm.v_load = (r_job == JOB_VNORM);
                    case (r_job)
                        JOB_HSTEP: begin
                            n_job   = JOB_VSTEP;
                            n_state = SEQ_LAUNCH;
                        end
                        JOB_VSTEP: begin
                            n_job   = JOB_HNORM;
                            n_state = SEQ_LAUNCH;
                        end
                        JOB_HNORM: begin
                            n_job   = JOB_VNORM;
                            n_state = SEQ_LAUNCH;
                        end
                        default: begin
                            n_job   = JOB_HSTEP;
                            n_state = SEQ_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= CFG_DATA_W'(1);
            r_src_h   <= CFG_DATA_W'(1);
            r_dst_w   <= CFG_DATA_W'(1);
            r_dst_h   <= CFG_DATA_W'(1);
            r_key     <= 1'b0;
            r_h_whole <= COORD_W'(1);
            r_v_whole <= COORD_W'(1);
            r_h_frac  <= '0;
            r_v_frac  <= '0;
        end else begin
            if (cfg_wr) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_SOURCE_WIDTH:  r_src_w <= i_cfg_data;
                    CFG_SOURCE_HEIGHT: r_src_h <= i_cfg_data;
                    CFG_DEST_WIDTH:    r_dst_w <= i_cfg_data;
                    CFG_DEST_HEIGHT:   r_dst_h <= i_cfg_data;
                    CFG_KEY_ENABLE:    r_key   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (job_end && r_job == JOB_HSTEP) begin
                r_h_whole <= COORD_W'(div_quo);
                r_h_frac  <= CNT_W'(div_rem);
            end
            if (job_end && r_job == JOB_VSTEP) begin
                r_v_whole <= COORD_W'(div_quo);
                r_v_frac  <= CNT_W'(div_rem);
            end
        end
    end

    nnsb_div #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_done  (div_done)
    );

    assign o_busy       = (r_state != SEQ_IDLE);
    assign o_dw         = eff_dw;
    assign o_dh         = eff_dh;
    assign o_h_whole    = r_h_whole;
    assign o_v_whole    = r_v_whole;
    assign o_h_frac     = r_h_frac;
    assign o_v_frac     = r_v_frac;
    assign o_key_enable = r_key;
    assign o_norm_quo   = COORD_W'(div_quo);
    assign o_norm_rem   = CNT_W'(div_rem);

endmodule

[rtl/nnsb_walk.sv]
// destination walker: position counters, error accumulators and the
// registered result stage
// depends on nnsb_pkg
module nnsb_walk
    import nnsb_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_busy,
    input  logic [$clog2(MAX_DIMENSION+1)-1:0]    i_dw,
    input  logic [$clog2(MAX_DIMENSION+1)-1:0]    i_dh,
    input  logic [COORD_W-1:0]                    i_h_whole,
    input  logic [COORD_W-1:0]                    i_v_whole,
    input  logic [$clog2(MAX_DIMENSION)-1:0]      i_h_frac,
    input  logic [$clog2(MAX_DIMENSION)-1:0]      i_v_frac,
    input  logic                                  i_key_enable,
    input  t_norm_ctl                             i_norm,
    input  logic [COORD_W-1:0]                    i_norm_quo,
    input  logic [$clog2(MAX_DIMENSION)-1:0]      i_norm_rem,
    output logic [$clog2(MAX_DIMENSION)-1:0]      o_herr,
    output logic [$clog2(MAX_DIMENSION)-1:0]      o_verr,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [PIXEL_W-1:0]                    s_axis_tdata,
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [63:0]                           m_axis_tdata,
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast
);

    localparam int ESZ_W = $clog2(MAX_DIMENSION + 1);
    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int EW    = ESZ_W + 1;

    logic [CNT_W-1:0]   r_col,  n_col,  cur_col;
    logic [CNT_W-1:0]   r_row,  n_row,  cur_row;
    logic [CNT_W-1:0]   r_herr, n_herr, cur_herr;
    logic [CNT_W-1:0]   r_verr, n_verr, cur_verr;
    logic [COORD_W-1:0] r_scol, n_scol, cur_scol;
    logic [COORD_W-1:0] r_srow, n_srow, cur_srow;
    logic [COORD_W-1:0] r_hq,   n_hq,   cur_hq;
    logic [COORD_W-1:0] r_vq,   n_vq,   cur_vq;
    logic               r_valid;

    logic [63:0]        r_data;
    logic               r_we;
    logic               r_last;

    logic               accept;
    logic [EW-1:0]      col_p1;
    logic [EW-1:0]      row_p1;
    logic               last_col;
    logic               last_row;
    logic [EW-1:0]      e_h;
    logic [EW-1:0]      e_v;
    logic               h_carry;
    logic               v_carry;
    logic [COORD_W-1:0] step_scol;
    logic [COORD_W-1:0] step_srow;
    logic               pix_we;

    assign s_axis_tready = !i_busy && (!r_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        cur_col  = s_axis_tuser ? '0 : r_col;
        cur_row  = s_axis_tuser ? '0 : r_row;
        cur_herr = s_axis_tuser ? '0 : r_herr;
        cur_verr = s_axis_tuser ? '0 : r_verr;
        cur_scol = s_axis_tuser ? '0 : r_scol;
        cur_srow = s_axis_tuser ? '0 : r_srow;
        cur_hq   = s_axis_tuser ? '0 : r_hq;
        cur_vq   = s_axis_tuser ? '0 : r_vq;

        col_p1   = EW'(cur_col) + EW'(1);
        row_p1   = EW'(cur_row) + EW'(1);
        last_col = col_p1 >= EW'(i_dw);
        last_row = row_p1 >= EW'(i_dh);

        e_h       = EW'(cur_herr) + EW'(i_h_frac);
        e_v       = EW'(cur_verr) + EW'(i_v_frac);
        h_carry   = e_h >= EW'(i_dw);
        v_carry   = e_v >= EW'(i_dh);
        step_scol = cur_scol + i_h_whole + cur_hq + COORD_W'(h_carry);
        step_srow = cur_srow + i_v_whole + cur_vq + COORD_W'(v_carry);
        pix_we    = !(i_key_enable && s_axis_tdata == '0);

        n_col  = r_col;
        n_row  = r_row;
        n_herr = r_herr;
        n_verr = r_verr;
        n_scol = r_scol;
        n_srow = r_srow;
        n_hq   = r_hq;
        n_vq   = r_vq;

        if (accept) begin
            n_row  = cur_row;
            n_verr = cur_verr;
            n_srow = cur_srow;
            n_vq   = cur_vq;
            if (!last_col) begin
                n_col  = CNT_W'(col_p1);
                n_herr = CNT_W'(h_carry ? e_h - EW'(i_dw) : e_h);
                n_scol = step_scol;
                n_hq   = '0;
            end else begin
                n_col  = '0;
                n_herr = '0;
                n_scol = '0;
                n_hq   = '0;
                if (!last_row) begin
                    n_row  = CNT_W'(row_p1);
                    n_verr = CNT_W'(v_carry ? e_v - EW'(i_dh) : e_v);
                    n_srow = step_srow;
                    n_vq   = '0;
                end else begin
                    n_row  = '0;
                    n_verr = '0;
                    n_srow = '0;
                    n_vq   = '0;
                end
            end
        end else begin
            if (i_norm.h_load) begin
                n_herr = i_norm_rem;
                n_hq   = r_hq + i_norm_quo;
            end
            if (i_norm.v_load) begin
                n_verr = i_norm_rem;
                n_vq   = r_vq + i_norm_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_herr  <= '0;
            r_verr  <= '0;
            r_scol  <= '0;
            r_srow  <= '0;
            r_hq    <= '0;
            r_vq    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_herr <= n_herr;
            r_verr <= n_verr;
            r_scol <= n_scol;
            r_srow <= n_srow;
            r_hq   <= n_hq;
            r_vq   <= n_vq;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= {n_srow, n_scol, s_axis_tdata,
                       COORD_W'(cur_row), COORD_W'(cur_col)};
            r_we   <= pix_we;
            r_last <= last_col && last_row;
        end
    end

    assign o_herr        = r_herr;
    assign o_verr        = r_verr;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_we;
    assign m_axis_tlast  = r_last;

endmodule

[rtl/nearest_neighbor_stretch_blit.sv]
// Nearest-neighbor stretch blit for 16-bit pixels, walking the destination
// rectangle in row order. Each input transaction carries the source pixel
// named by the previous result's fetch coordinate; each output transaction
// carries one destination pixel with its position, write enable and the next
// fetch coordinate. Throughput is one pixel per clock while the output is not
// stalled and no recompute runs; the result is registered and appears in the
// cycle after its input is taken, and input ready follows the output register.
// A configuration write starts a recompute on one shared bit-serial divider:
// four divisions (two step ratios, two accumulator renormalizations), during
// which neither input pixels nor further configuration writes are taken.
// depends on nnsb_pkg, nnsb_cfg, nnsb_walk
module nearest_neighbor_stretch_blit
    import nnsb_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIXEL_W-1:0]     s_axis_tdata,   // pixel_in
    input  logic                   s_axis_tuser,   // frame_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // dest_x, dest_y, pixel_out, fetch_x, fetch_y
    output logic [63:0]            m_axis_tdata,
    output logic                   m_axis_tuser,   // write_enable
    output logic                   m_axis_tlast
);

    localparam int ESZ_W = $clog2(MAX_DIMENSION + 1);
    localparam int CNT_W = $clog2(MAX_DIMENSION);

    logic               busy;
    logic [ESZ_W-1:0]   dw;
    logic [ESZ_W-1:0]   dh;
    logic [COORD_W-1:0] h_whole;
    logic [COORD_W-1:0] v_whole;
    logic [CNT_W-1:0]   h_frac;
    logic [CNT_W-1:0]   v_frac;
    logic               key_enable;
    t_norm_ctl          norm;
    logic [COORD_W-1:0] norm_quo;
    logic [CNT_W-1:0]   norm_rem;
    logic [CNT_W-1:0]   herr;
    logic [CNT_W-1:0]   verr;

    nnsb_cfg #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_herr       (herr),
        .i_verr       (verr),
        .o_busy       (busy),
        .o_dw         (dw),
        .o_dh         (dh),
        .o_h_whole    (h_whole),
        .o_v_whole    (v_whole),
        .o_h_frac     (h_frac),
        .o_v_frac     (v_frac),
        .o_key_enable (key_enable),
        .o_norm       (norm),
        .o_norm_quo   (norm_quo),
        .o_norm_rem   (norm_rem)
    );

    nnsb_walk #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_busy        (busy),
        .i_dw          (dw),
        .i_dh          (dh),
        .i_h_whole     (h_whole),
        .i_v_whole     (v_whole),
        .i_h_frac      (h_frac),
        .i_v_frac      (v_frac),
        .i_key_enable  (key_enable),
        .i_norm        (norm),
        .i_norm_quo    (norm_quo),
        .i_norm_rem    (norm_rem),
        .o_herr        (herr),
        .o_verr        (verr),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[rtl/nnsb_checker.sv]
// port-level checks for the stretch blit, attached by bind
// depends on nnsb_pkg and the top-level port list
module nnsb_checker
    import nnsb_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [PIXEL_W-1:0]     s_axis_tdata,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [63:0]            m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    // a configuration transaction always starts a recompute
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !s_axis_tready)
        else $error("input ready right after configuration write");

    // input is only taken while the sequencer is idle
    a_ready_implies_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> o_cfg_ready)
        else $error("input ready while recompute running");

    // every accepted pixel shows up in the cycle after it is taken
    a_one_cycle_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("result missing after input transaction");

    // skipped writes only come from a zero pixel
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[39:24] == '0)
        else $error("write disabled for nonzero pixel");

    // stalled result holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

endmodule

bind nearest_neighbor_stretch_blit nnsb_checker u_nnsb_checker (.*);

[bench/testbench.sv]
// self-checking bench for nearest_neighbor_stretch_blit: a table of directed pixels and
// register writes, then random frames, checked against typed results or a walk predictor kept here
// depends on nnsb_pkg and the nearest_neighbor_stretch_blit rtl
module testbench;
    import nnsb_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RANDOM_PIXELS  = 1500;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES  = 16;
    localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED_INDEX = 3'd7;
    localparam logic [CFG_DATA_W-1:0] SIZE_CEILING     = CFG_DATA_W'(MAX_DIMENSION_DEF);

    typedef struct packed {
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [PIXEL_W-1:0] pixel;
        logic               write_en;
        logic [COORD_W-1:0] fetch_x;
        logic [COORD_W-1:0] fetch_y;
        logic               frame_last;
    } blit_result_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_PIXEL
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic [PIXEL_W-1:0]    pixel;
        logic                  start;
        logic                  typed;
        blit_result_t          result;
    } script_row_t;

    localparam blit_result_t NONE = '0;
    localparam int SCRIPT_LEN = 43;

    // typed results: single-pixel frames, key on zero, a column count past a shrunk width
    localparam script_row_t BLIT_SCRIPT [0:SCRIPT_LEN-1] = '{
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'hFFFF, 1'b0, 1'b1,
          '{12'd0, 12'd0, 16'hFFFF, 1'b1, 12'd0, 12'd0, 1'b1}},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h0000, 1'b1, 1'b1,
          '{12'd0, 12'd0, 16'h0000, 1'b1, 12'd0, 12'd0, 1'b1}},
        '{ROW_WRITE, CFG_KEY_ENABLE, 13'h1, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h0000, 1'b0, 1'b1,
          '{12'd0, 12'd0, 16'h0000, 1'b0, 12'd0, 12'd0, 1'b1}},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h8000, 1'b0, 1'b1,
          '{12'd0, 12'd0, 16'h8000, 1'b1, 12'd0, 12'd0, 1'b1}},
        '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'h0, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_DEST_WIDTH, 13'h1FFF, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h0000, 1'b1, 1'b1,
          '{12'd0, 12'd0, 16'h0000, 1'b0, 12'd0, 12'd0, 1'b0}},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h1234, 1'b0, 1'b1,
          '{12'd1, 12'd0, 16'h1234, 1'b1, 12'd0, 12'd0, 1'b0}},
        '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'h1000, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_DEST_WIDTH, 13'h1, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_SOURCE_HEIGHT, 13'h1FFF, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_DEST_HEIGHT, 13'h0, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_UNUSED_INDEX, 13'h1FFF, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h0000, 1'b0, 1'b1,
          '{12'd2, 12'd0, 16'h0000, 1'b0, 12'd0, 12'd0, 1'b1}},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h5555, 1'b0, 1'b1,
          '{12'd0, 12'd0, 16'h5555, 1'b1, 12'd0, 12'd0, 1'b1}},
        '{ROW_WRITE, CFG_KEY_ENABLE, 13'h0, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'd3, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_DEST_WIDTH, 13'd2, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_SOURCE_HEIGHT, 13'd2, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_DEST_HEIGHT, 13'd3, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h0000, 1'b1, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'hA5A5, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'hFFFF, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h0001, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h7FFE, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h8001, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'd5, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_DEST_WIDTH, 13'd4, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h1111, 1'b1, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h2222, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_DEST_WIDTH, 13'd2, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h3333, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h4444, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h5555, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'h1FFF, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_DEST_WIDTH, 13'd3, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_SOURCE_HEIGHT, 13'h1001, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_WRITE, CFG_DEST_HEIGHT, 13'd2, 16'h0, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'hFEDC, 1'b1, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h0000, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h0001, 1'b0, 1'b0, NONE},
        '{ROW_PIXEL, CFG_SOURCE_WIDTH, 13'h0, 16'h0002, 1'b0, 1'b0, NONE}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIXEL_W-1:0]    s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    nearest_neighbor_stretch_blit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // register copies and walk state of the predictor
    logic [CFG_DATA_W-1:0] src_width_reg  = 13'd1;
    logic [CFG_DATA_W-1:0] src_height_reg = 13'd1;
    logic [CFG_DATA_W-1:0] dst_width_reg  = 13'd1;
    logic [CFG_DATA_W-1:0] dst_height_reg = 13'd1;
    logic                  key_reg        = 1'b0;
    logic [COORD_W-1:0]    walk_col       = '0;
    logic [COORD_W-1:0]    walk_row       = '0;
    logic [COORD_W-1:0]    h_error        = '0;
    logic [COORD_W-1:0]    v_error        = '0;
    logic [COORD_W-1:0]    fetch_col      = '0;
    logic [COORD_W-1:0]    fetch_row      = '0;

    blit_result_t pending_pixels[$];
    int           mismatches = 0;
    bit           steady     = 1'b0;
    int           ready_hold = 0;

    function automatic int draw_idle_cycles();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] effective_size(logic [CFG_DATA_W-1:0] v);
        if (v == '0)
            return 13'd1;
        if (v > SIZE_CEILING)
            return SIZE_CEILING;
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return CFG_DATA_W'($urandom_range(1, 12));
        if (roll < 85)
            return CFG_DATA_W'($urandom_range(13, 64));
        if (roll < 90)
            return '0;
        if (roll < 94)
            return SIZE_CEILING;
        if (roll < 97)
            return CFG_DATA_W'($urandom_range(MAX_DIMENSION_DEF + 1, 8191));
        return CFG_DATA_W'($urandom_range(1, 8191));
    endfunction

    function automatic void restart_walk();
        walk_col  = '0;
        walk_row  = '0;
        h_error   = '0;
        v_error   = '0;
        fetch_col = '0;
        fetch_row = '0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SOURCE_WIDTH:  src_width_reg  = val;
            CFG_SOURCE_HEIGHT: src_height_reg = val;
            CFG_DEST_WIDTH:    dst_width_reg  = val;
            CFG_DEST_HEIGHT:   dst_height_reg = val;
            CFG_KEY_ENABLE:    key_reg        = val[0];
            default: ;
        endcase
    endfunction

    function automatic blit_result_t advance_walk(logic [PIXEL_W-1:0] px, logic start);
        logic [CFG_DATA_W-1:0] sw, sh, dw, dh, sum;
        logic                  last_col, last_row;
        blit_result_t          r;
        sw = effective_size(src_width_reg);
        sh = effective_size(src_height_reg);
        dw = effective_size(dst_width_reg);
        dh = effective_size(dst_height_reg);
        if (start)
            restart_walk();
        last_col     = ({1'b0, walk_col} + 13'd1) >= dw;
        last_row     = ({1'b0, walk_row} + 13'd1) >= dh;
        r.dest_x     = walk_col;
        r.dest_y     = walk_row;
        r.pixel      = px;
        r.write_en   = !(key_reg && px == '0);
        r.frame_last = last_col && last_row;
        if (!last_col) begin
            sum       = {1'b0, h_error} + sw % dw;
            walk_col  = walk_col + 1'b1;
            fetch_col = fetch_col + COORD_W'(sw / dw) + COORD_W'(sum / dw);
            h_error   = COORD_W'(sum % dw);
        end else begin
            walk_col  = '0;
            h_error   = '0;
            fetch_col = '0;
            if (!last_row) begin
                sum       = {1'b0, v_error} + sh % dh;
                walk_row  = walk_row + 1'b1;
                fetch_row = fetch_row + COORD_W'(sh / dh) + COORD_W'(sum / dh);
                v_error   = COORD_W'(sum % dh);
            end else begin
                restart_walk();
            end
        end
        r.fetch_x = fetch_col;
        r.fetch_y = fetch_row;
        return r;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic start,
                              input logic typed, input blit_result_t typed_result);
        int           gap;
        blit_result_t predicted;
        gap = draw_idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = advance_walk(px, start);
        pending_pixels.push_back(typed ? typed_result : predicted);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        int gap;
        gap = draw_idle_cycles();
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, val);
    endtask

    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        int stall;
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (steady || !m_axis_tready) begin
            m_axis_tready <= 1'b1;
            ready_hold = $urandom_range(0, 20);
        end else begin
            stall = draw_idle_cycles();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                ready_hold = stall - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        blit_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected output transaction, expected none, actual tdata %0h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                compare_field("dest_x", want.dest_x, m_axis_tdata[11:0]);
                compare_field("dest_y", want.dest_y, m_axis_tdata[23:12]);
                compare_field("pixel_out", want.pixel, m_axis_tdata[39:24]);
                compare_field("fetch_x", want.fetch_x, m_axis_tdata[51:40]);
                compare_field("fetch_y", want.fetch_y, m_axis_tdata[63:52]);
                compare_field("write_enable", want.write_en, m_axis_tuser);
                compare_field("frame_last", want.frame_last, m_axis_tlast);
            end
        end
    end

    initial begin
        row_kind_t last_kind;
        int        pixels_sent;
        int        phase_pixels;
        logic      start;
        last_kind   = ROW_PIXEL;
        pixels_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (BLIT_SCRIPT[r].kind == ROW_WRITE) begin
                if (last_kind == ROW_PIXEL)
                    drain_pixels();
                write_register(BLIT_SCRIPT[r].index, BLIT_SCRIPT[r].value);
            end else begin
                if (last_kind == ROW_WRITE)
                    i_cfg_valid <= 1'b0;
                send_pixel(BLIT_SCRIPT[r].pixel, BLIT_SCRIPT[r].start,
                           BLIT_SCRIPT[r].typed, BLIT_SCRIPT[r].result);
            end
            last_kind = BLIT_SCRIPT[r].kind;
        end

        while (pixels_sent < RANDOM_PIXELS) begin
            drain_pixels();
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i <= CFG_KEY_ENABLE; i++) begin
                if ($urandom_range(0, 3) != 0)
                    write_register(CFG_IDX_W'(i), (i == CFG_KEY_ENABLE) ?
                                   CFG_DATA_W'($urandom) : draw_size());
            end
            if ($urandom_range(0, 9) == 0)
                write_register(CFG_IDX_W'($urandom_range(CFG_KEY_ENABLE + 1, CFG_UNUSED_INDEX)),
                               CFG_DATA_W'($urandom));
            i_cfg_valid <= 1'b0;
            phase_pixels = $urandom_range(60, 180);
            for (int n = 0; n < phase_pixels; n++) begin
                // frames mostly open at the walk origin; a few restarts land mid-frame
                if (n == 0)
                    start = $urandom_range(0, 1);
                else if (walk_col == '0 && walk_row == '0)
                    start = ($urandom_range(0, 4) != 0);
                else
                    start = ($urandom_range(0, 29) == 0);
                send_pixel(($urandom_range(0, 6) == 0) ? '0 : PIXEL_W'($urandom),
                           start, 1'b0, NONE);
            end
            pixels_sent += phase_pixels;
        end

        steady = 1'b0;
        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
